/* src/binomial_coefficient_core_macros.svh */
// assertion macros shared by the binomial coefficient checker
`ifndef BINOMIAL_COEFFICIENT_CORE_MACROS_SVH
`define BINOMIAL_COEFFICIENT_CORE_MACROS_SVH

// same-cycle implication, disabled while the active-low reset is low
`define BINCO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binomial coefficient check failed");

// next-cycle implication, disabled while the active-low reset is low
`define BINCO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binomial coefficient check failed");

`endif

/* src/binco_pkg.sv */
// package: widths, microcode table and exact-division constants of the binomial core
package binco_pkg;

    // field widths and limits
    localparam int unsigned N_W   = 7;
    localparam int unsigned C_W   = 63;
    localparam int unsigned MAX_N = 127;
    localparam int unsigned KK_W  = 6;
    localparam int unsigned P_W   = C_W + N_W;
    localparam logic [C_W-1:0] SAT63 = {C_W{1'b1}};

    // microcode step addresses
    localparam int unsigned PC_W = 3;
    localparam logic [PC_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] ST_SETUP = 3'd1;
    localparam logic [PC_W-1:0] ST_MUL   = 3'd2;
    localparam logic [PC_W-1:0] ST_PP0   = 3'd3;
    localparam logic [PC_W-1:0] ST_PP1   = 3'd4;
    localparam logic [PC_W-1:0] ST_PP2   = 3'd5;
    localparam logic [PC_W-1:0] ST_DONE  = 3'd6;
    localparam logic [PC_W-1:0] ST_SPARE = 3'd7;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_SETUP = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_PP0   = 3'd4;
    localparam logic [2:0] OP_PP1   = 3'd5;
    localparam logic [2:0] OP_PP2   = 3'd6;
    localparam logic [2:0] OP_DONE  = 3'd7;

    // jump conditions
    localparam logic [2:0] CND_NEXT   = 3'd0;
    localparam logic [2:0] CND_ALWAYS = 3'd1;
    localparam logic [2:0] CND_WAIT   = 3'd2;
    localparam logic [2:0] CND_EXIT   = 3'd3;
    localparam logic [2:0] CND_LOOP   = 3'd4;

    typedef struct packed {
        logic [2:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef t_ctrl t_ucode [2**PC_W];

    // control program: one word per step
    localparam t_ucode UCODE = '{
        '{op: OP_LOAD,  cond: CND_WAIT,   target: ST_IDLE},
        '{op: OP_SETUP, cond: CND_EXIT,   target: ST_DONE},
        '{op: OP_MUL,   cond: CND_EXIT,   target: ST_DONE},
        '{op: OP_PP0,   cond: CND_NEXT,   target: ST_IDLE},
        '{op: OP_PP1,   cond: CND_NEXT,   target: ST_IDLE},
        '{op: OP_PP2,   cond: CND_LOOP,   target: ST_MUL},
        '{op: OP_DONE,  cond: CND_ALWAYS, target: ST_IDLE},
        '{op: OP_NONE,  cond: CND_ALWAYS, target: ST_IDLE}
    };

    // exact division by i: strip the power of two, multiply by the odd inverse mod 2^64
    localparam int unsigned DIV_N = 2**KK_W;
    typedef logic [63:0] t_inv_rom [DIV_N];
    typedef logic [2:0]  t_shift_rom [DIV_N];

    function automatic t_inv_rom f_build_inv();
        t_inv_rom    tbl;
        logic [63:0] o;
        logic [63:0] x;
        for (int idx = 0; idx < DIV_N; idx++) begin
            if (idx == 0) begin
                tbl[idx] = 64'd0;
            end else begin
                o = 64'(idx);
                while (o[0] == 1'b0) begin
                    o = o >> 1;
                end
                // each refinement step doubles the number of correct low bits
                x = o;
                for (int s = 0; s < 5; s++) begin
                    x = x * (64'd2 - o * x);
                end
                tbl[idx] = x;
            end
        end
        return tbl;
    endfunction

    function automatic t_shift_rom f_build_shift();
        t_shift_rom  tbl;
        logic [63:0] o;
        logic [2:0]  t;
        for (int idx = 0; idx < DIV_N; idx++) begin
            o = 64'(idx);
            t = 3'd0;
            if (idx != 0) begin
                while (o[0] == 1'b0) begin
                    o = o >> 1;
                    t = t + 3'd1;
                end
            end
            tbl[idx] = t;
        end
        return tbl;
    endfunction

    localparam t_inv_rom   INV_ROM   = f_build_inv();
    localparam t_shift_rom SHIFT_ROM = f_build_shift();

endpackage

/* src/binomial_coefficient_core.sv */
// binomial coefficient core: microcoded sequencer with multiply and exact-divide datapath
//
// Computes C(n,k) exactly as c_i = c_(i-1) * (n-k'+i) / i for i = 1..k', with
// k' = min(k, n-k). Each step is one 63x7 multiply, then the exact division by i
// as a shift plus a multiply by the odd inverse of i, done as three 32x32 partial
// products on one shared multiplier, so a step runs through MUL, PP0, PP1 and PP2.
// An item holds the block from the cycle it is taken until its result is shown,
// ending sooner when the value passes 2^63-1, which ends the loop early. The result
// appears on o_coefficient/o_overflow with o_valid high for exactly one cycle;
// the receiver cannot stall, so capture it then.
// k above n gives 0; a result beyond 2^63-1 saturates with o_overflow set.
// o_busy is low in the cycle o_valid is high, so a new start may be issued there.
module binomial_coefficient_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [binco_pkg::N_W-1:0]  i_n_total,
    input  logic [binco_pkg::N_W-1:0]  i_k_chosen,
    output logic                       o_valid,
    output logic [binco_pkg::C_W-1:0]  o_coefficient,
    output logic                       o_overflow
);
    import binco_pkg::*;

    // control registers
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_valid;
    logic            r_sat;

    // datapath registers
    logic [N_W-1:0]  r_n;
    logic [N_W-1:0]  r_k;
    logic [KK_W-1:0] r_kk;
    logic [KK_W-1:0] r_i;
    logic [C_W-1:0]  r_c;
    logic [63:0]     r_q;
    logic [63:0]     r_acc;
    logic [C_W-1:0]  r_coef;
    logic            r_ovf;

    t_ctrl           w_ctrl;
    logic [N_W-1:0]  w_diff;
    logic            w_k_gt_n;
    logic            w_range;
    logic [N_W-1:0]  w_kk;
    logic [N_W-1:0]  w_m;
    logic [P_W-1:0]  w_prod;
    logic [P_W-1:0]  w_shr;
    logic            w_mul_ovf;
    logic [63:0]     w_inv;
    logic [31:0]     w_ma;
    logic [31:0]     w_mb;
    logic [63:0]     w_mp;
    logic [31:0]     w_hi_sum;
    logic            w_exit;
    logic            w_more;
    logic            w_jump;

    // current control word
    assign w_ctrl = UCODE[r_pc];

    // setup: reduced k and the special cases
    assign w_diff   = r_n - r_k;
    assign w_k_gt_n = (r_k > r_n);
    assign w_range  = (r_n > N_W'(MAX_N));
    assign w_kk     = (r_k > w_diff) ? w_diff : r_k;

    // multiply step: c * (n - k' + i), then strip the power of two of i
    assign w_m       = r_n - {1'b0, r_kk} + {1'b0, r_i};
    assign w_prod    = P_W'(r_c) * P_W'(w_m);
    assign w_shr     = w_prod >> SHIFT_ROM[r_i];
    assign w_mul_ovf = (w_prod[P_W-1:C_W] >= {1'b0, r_i});

    // shared 32x32 multiplier for the inverse product
    assign w_inv = INV_ROM[r_i];
    always_comb begin
        case (w_ctrl.op)
            OP_PP1: begin
                w_ma = r_q[31:0];
                w_mb = w_inv[63:32];
            end
            OP_PP2: begin
                w_ma = r_q[63:32];
                w_mb = w_inv[31:0];
            end
            default: begin
                w_ma = r_q[31:0];
                w_mb = w_inv[31:0];
            end
        endcase
    end
    assign w_mp     = w_ma * w_mb;
    assign w_hi_sum = r_acc[63:32] + w_mp[31:0];

    // jump conditions
    always_comb begin
        case (w_ctrl.op)
            OP_SETUP: w_exit = w_k_gt_n || w_range || (w_kk == '0);
            OP_MUL:   w_exit = w_mul_ovf;
            default:  w_exit = 1'b0;
        endcase
    end
    assign w_more = (r_i != r_kk);

    always_comb begin
        case (w_ctrl.cond)
            CND_NEXT:   w_jump = 1'b0;
            CND_ALWAYS: w_jump = 1'b1;
            CND_WAIT:   w_jump = !i_start;
            CND_EXIT:   w_jump = w_exit;
            CND_LOOP:   w_jump = w_more;
            default:    w_jump = 1'b1;
        endcase
    end
    assign n_pc = w_jump ? w_ctrl.target : r_pc + PC_W'(1);

    // step counter and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= ST_IDLE;
            r_valid <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= (w_ctrl.op == OP_DONE);
            case (w_ctrl.op)
                OP_SETUP: r_sat <= !w_k_gt_n && w_range;
                OP_MUL: begin
                    if (w_mul_ovf) begin
                        r_sat <= 1'b1;
                    end
                end
                default: r_sat <= r_sat;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (w_ctrl.op)
            OP_LOAD: begin
                if (i_start) begin
                    r_n <= i_n_total;
                    r_k <= i_k_chosen;
                end
            end
            OP_SETUP: begin
                r_kk <= w_kk[KK_W-1:0];
                r_i  <= KK_W'(1);
                r_c  <= w_k_gt_n ? '0 : C_W'(1);
            end
            OP_MUL: begin
                r_q <= w_shr[63:0];
            end
            OP_PP0: begin
                r_acc <= w_mp;
            end
            OP_PP1: begin
                r_acc[63:32] <= w_hi_sum;
            end
            OP_PP2: begin
                r_c <= {w_hi_sum[30:0], r_acc[31:0]};
                r_i <= r_i + KK_W'(1);
            end
            OP_DONE: begin
                r_coef <= r_sat ? SAT63 : r_c;
                r_ovf  <= r_sat;
            end
            default: begin
                r_c <= r_c;
            end
        endcase
    end

    // outputs
    assign o_busy        = (r_pc != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_coefficient = r_coef;
    assign o_overflow    = r_ovf;

endmodule

/* src/binco_checker.sv */
// port-level checker for the binomial coefficient core, bound to binomial_coefficient_core
`include "binomial_coefficient_core_macros.svh"

module binco_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       i_busy,
    input logic                       i_valid,
    input logic [binco_pkg::C_W-1:0]  i_coefficient,
    input logic                       i_overflow
);
    import binco_pkg::*;

    // a taken transaction makes the core busy
    `BINCO_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)

    // the result strobe is a single-cycle pulse
    `BINCO_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, i_valid, !i_valid)

    // the core is free again while its result is shown
    `BINCO_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, i_valid, !i_busy)

    // an overflowed result is saturated
    `BINCO_ASSERT_NOW(a_ovf_sat, i_clk, i_rst_n, i_valid && i_overflow, i_coefficient == SAT63)

endmodule

bind binomial_coefficient_core binco_checker u_binco_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .i_busy        (o_busy),
    .i_valid       (o_valid),
    .i_coefficient (o_coefficient),
    .i_overflow    (o_overflow)
);
